// ===== hdl/msort_pkg.sv =====
// Package for the merge sort engine: shared payload widths.
// No dependencies; the interfaces and every module but msort_ram import it.
package msort_pkg;

  // Width of the value fields on both channels
  localparam int VALUE_W = 32;

endpackage

// ===== hdl/msort_if.sv =====
// Valid/ready channel interfaces for the merge sort engine.
// Depends on msort_pkg for the payload widths.
interface msort_in_if import msort_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface msort_out_if import msort_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink (input valid, input sorted_value, input final_res, output ready);
endinterface

// ===== hdl/msort_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the entry written in the same cycle returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/merge_sort_engine_unit.sv =====
// Loading accepts values while idle; the sort then runs ceil(log2 n) merge passes,
// each a prime step and then one merged value per cycle out of the RAM read ports.
// Emitting runs fetch, load and hold for each value; hold waits for the sink.
// Reset (rst_n, synchronous, active low) clears the sequencer, fill count and
// output valid; the two RAMs are not cleared and only written entries are read.
module merge_sort_engine_unit import msort_pkg::*; #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  msort_in_if.sink     in_ch,
  msort_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE,
    ST_FETCH,
    ST_LOAD,
    ST_HOLD
  } state_t;

  state_t                    state_r;
  logic [CW-1:0]             fill_r;
  logic [CW-1:0]             n_r;
  logic [CW-1:0]             w_r;
  logic [CW-1:0]             i_r, j_r, k_r, mid_r, hi_r, o_r;
  logic                      src_odd_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_final_r;

  logic [CW-1:0]             i_nxt, j_nxt, k_nxt, mid_nxt, hi_nxt;
  logic [CW-1:0]             w_nxt;
  logic                      src_odd_nxt;

  logic [DATA_WIDTH-1:0]     rd_a_even, rd_b_even, rd_a_odd, rd_b_odd;
  logic signed [DATA_WIDTH-1:0] src_a, src_b, in_data, wr_data;
  logic [AW-1:0]             rd_addr_a, rd_addr_b, wr_addr;
  logic                      we_even, we_odd;

  logic                      in_xfer, set_end, merge_en, out_phase;
  logic                      take_left, run_end, pass_end, pass_done;
  logic [CW-1:0]             fill_inc, k_inc, o_inc;
  logic [SW-1:0]             n_ext, w2, w4, nr_mid_sum, nr_hi_sum;
  logic [CW-1:0]             nr_mid, nr_hi, np_hi;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign fill_inc  = fill_r + CW'(1);
  assign set_end   = in_ch.last || (fill_inc == CW'(MAX_ITEMS));
  assign in_data   = DATA_WIDTH'(in_ch.value);
  assign merge_en  = (state_r == ST_MERGE);
  assign out_phase = (state_r == ST_FETCH) || (state_r == ST_LOAD) || (state_r == ST_HOLD);

  // Pick the source store of the current pass
  assign src_a = src_odd_r ? rd_a_odd : rd_a_even;
  assign src_b = src_odd_r ? rd_b_odd : rd_b_even;

  // Merge decision: left run wins ties, so the sort stays stable
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || (src_a <= src_b));
  assign k_inc     = k_r + CW'(1);
  assign o_inc     = o_r + CW'(1);
  assign run_end   = (k_inc == hi_r);
  assign pass_end  = (k_inc == n_r);

  // Bounds of the next run pair and of the next pass
  assign n_ext      = SW'(n_r);
  assign w2         = SW'(w_r) << 1;
  assign w4         = w2 << 1;
  assign nr_mid_sum = SW'(hi_r) + SW'(w_r);
  assign nr_hi_sum  = SW'(hi_r) + w2;
  assign nr_mid     = (nr_mid_sum > n_ext) ? n_r : nr_mid_sum[CW-1:0];
  assign nr_hi      = (nr_hi_sum > n_ext) ? n_r : nr_hi_sum[CW-1:0];
  assign np_hi      = (w4 > n_ext) ? n_r : w4[CW-1:0];
  assign pass_done  = (w2 >= n_ext);

  // Next merge pointers; read addresses follow them so data lines up next cycle
  always_comb begin
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    w_nxt       = w_r;
    src_odd_nxt = src_odd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && set_end) begin
          i_nxt       = '0;
          j_nxt       = CW'(1);
          k_nxt       = '0;
          mid_nxt     = CW'(1);
          hi_nxt      = (fill_inc >= CW'(2)) ? CW'(2) : fill_inc;
          w_nxt       = CW'(1);
          src_odd_nxt = 1'b0;
        end
      end
      ST_MERGE: begin
        i_nxt = i_r + CW'(take_left);
        j_nxt = j_r + CW'(!take_left);
        k_nxt = k_inc;
        if (run_end) begin
          if (pass_end) begin
            src_odd_nxt = !src_odd_r;
            w_nxt       = w2[CW-1:0];
            i_nxt       = '0;
            k_nxt       = '0;
            j_nxt       = w2[CW-1:0];
            mid_nxt     = w2[CW-1:0];
            hi_nxt      = np_hi;
          end else begin
            i_nxt   = hi_r;
            j_nxt   = nr_mid;
            mid_nxt = nr_mid;
            hi_nxt  = nr_hi;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // RAM port control: loading writes the even store, merges write the other store
  assign rd_addr_a = out_phase ? o_r[AW-1:0] : i_nxt[AW-1:0];
  assign rd_addr_b = j_nxt[AW-1:0];
  assign wr_addr   = (state_r == ST_IDLE) ? fill_r[AW-1:0] : k_r[AW-1:0];
  assign wr_data   = (state_r == ST_IDLE) ? in_data : (take_left ? src_a : src_b);
  assign we_even   = in_xfer || (merge_en && src_odd_r);
  assign we_odd    = merge_en && !src_odd_r;

  msort_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store_even (
    .clk       (clk),
    .we        (we_even),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a_even),
    .rd_data_b (rd_b_even)
  );

  msort_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store_odd (
    .clk       (clk),
    .we        (we_odd),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a_odd),
    .rd_data_b (rd_b_odd)
  );

  // Sequencer: load, merge passes, emit
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    mid_r     <= mid_nxt;
    hi_r      <= hi_nxt;
    w_r       <= w_nxt;
    src_odd_r <= src_odd_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            fill_r <= fill_inc;
            if (set_end) begin
              n_r     <= fill_inc;
              o_r     <= '0;
              state_r <= (fill_inc == CW'(1)) ? ST_FETCH : ST_PRIME;
            end
          end
        end
        ST_PRIME: begin
          state_r <= ST_MERGE;
        end
        ST_MERGE: begin
          if (run_end && pass_end) begin
            state_r <= pass_done ? ST_FETCH : ST_PRIME;
          end
        end
        ST_FETCH: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          out_value_r <= VALUE_W'(src_a);
          out_final_r <= (o_inc == n_r);
          out_valid_r <= 1'b1;
          o_r         <= o_inc;
          state_r     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_final_r) begin
              fill_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_FETCH;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.final_res    = out_final_r;

endmodule

// ===== hdl/msort_chk.sv =====
// Port-level checker for the merge sort engine, bound to the top level.
// Depends on msort_pkg and on merge_sort_engine_unit's channel ports.
module msort_chk import msort_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] out_value,
  input logic                      out_final
);

  // Never take input while a sorted value is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while output valid");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_final))
    else $error("stalled result changed");

  // Close the input after the transfer that ends a set
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last");

  // Drop valid after the final result
  a_final_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final |=> !out_valid)
    else $error("valid after final result");

  // Keep input closed between results of one set
  a_mid_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final |=> !in_ready)
    else $error("input opened before final result");

endmodule

bind merge_sort_engine_unit msort_chk u_msort_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.sorted_value),
  .out_final (out_ch.final_res)
);

// ===== test/merge_sort_engine_unit_test.sv =====
// Self-checking bench for merge_sort_engine_unit: loads sets of signed values, predicts
// the stable ascending order and compares every sorted transfer against it.
// Depends on msort_pkg and the msort_in_if / msort_out_if channel interfaces.
module merge_sort_engine_unit_test;
  import msort_pkg::*;

  localparam int SET_MAX      = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_CYCLES  = 200;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct {
    value_t value;
    logic   last;
  } load_t;

  typedef struct {
    value_t value;
    logic   final_res;
  } sorted_t;

  logic clk;
  logic rst_n;

  msort_in_if  in_if ();
  msort_out_if out_if ();

  merge_sort_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  load_t   pending_q[$];
  value_t  open_set[$];
  sorted_t sorted_q[$];
  int      loads_done;
  int      results_seen;
  int      sets_closed;
  int      full_sets;
  int      mismatches;
  logic    steady;

  // Suspend random idling on both sides for a stretch of the run
  assign steady = loads_done >= 150 && loads_done < 260;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present the next pending value when the channel slot frees up, idling at random outside the steady stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
        in_if.valid <= 1'b1;
        in_if.value <= pending_q[0].value;
        in_if.last  <= pending_q[0].last;
        pending_q.delete(0);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall the sorted channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || $urandom_range(0, 99) >= 15;
    end
  end

  // Track loads, predict sorted order at set end, check every sorted transfer
  always @(posedge clk) begin
    value_t  run[$];
    value_t  key;
    int      i;
    int      j;
    sorted_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        open_set.push_back(in_if.value);
        loads_done++;
        if (in_if.last || open_set.size() == SET_MAX) begin
          if (!in_if.last) full_sets++;
          run = open_set;
          // Insertion sort; strict compare keeps equal values in arrival order
          for (i = 1; i < run.size(); i++) begin
            key = run[i];
            j = i - 1;
            while (j >= 0 && run[j] > key) begin
              run[j + 1] = run[j];
              j--;
            end
            run[j + 1] = key;
          end
          for (i = 0; i < run.size(); i++) begin
            want.value     = run[i];
            want.final_res = (i == run.size() - 1);
            sorted_q.push_back(want);
          end
          open_set.delete();
          sets_closed++;
        end
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (sorted_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, got value %0d final_res %0b",
                   $time, out_if.sorted_value, out_if.final_res);
        end else begin
          want = sorted_q.pop_front();
          if (out_if.sorted_value !== want.value) begin
            mismatches++;
            $display("%0t: sorted_value expected %0d, got %0d",
                     $time, want.value, out_if.sorted_value);
          end
          if (out_if.final_res !== want.final_res) begin
            mismatches++;
            $display("%0t: final_res expected %0b, got %0b",
                     $time, want.final_res, out_if.final_res);
          end
        end
      end
    end
  end

  function automatic void push_load(value_t v, logic l);
    load_t item;
    item.value = v;
    item.last  = l;
    pending_q.push_back(item);
  endfunction

  // Favor extremes and a narrow band so ties show up often
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return value_t'($urandom_range(0, 6)) - 3;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Queue one set; a full-size set without a last marker ends on store full
  function automatic void queue_set(int size, bit mark_end);
    int k;
    for (k = 0; k < size; k++) begin
      push_load(pick_value(), k == size - 1 && (mark_end || size < SET_MAX));
    end
  endfunction

  // Queue random sets, mostly short, some medium, a few at full size
  function automatic void queue_batch(int budget);
    int left;
    int size;
    left = budget;
    while (left > 0) begin
      case ($urandom_range(0, 19))
        0:          size = SET_MAX;
        1, 2, 3:    size = $urandom_range(13, 40);
        default:    size = $urandom_range(1, 12);
      endcase
      queue_set(size, 1'($urandom_range(0, 1)));
      left -= size;
    end
  endfunction

  // Hold until every queued value is sent and every predicted value has arrived
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_if.valid || sorted_q.size() != 0 ||
           open_set.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-value set at the most negative value
    push_load(32'h8000_0000, 1'b1);
    // Both extremes, largest first
    push_load(32'h7fff_ffff, 1'b0);
    push_load(32'h8000_0000, 1'b1);
    // Duplicates around zero and both extremes
    push_load(32'h0000_0000, 1'b0);
    push_load(32'hffff_ffff, 1'b0);
    push_load(32'h0000_0001, 1'b0);
    push_load(32'h7fff_ffff, 1'b0);
    push_load(32'h8000_0000, 1'b0);
    push_load(32'hffff_ffff, 1'b0);
    push_load(32'h0000_0000, 1'b1);
    // Already ascending
    push_load(1, 1'b0);
    push_load(2, 1'b0);
    push_load(3, 1'b0);
    push_load(4, 1'b1);
    // Strictly descending across the sign boundary
    push_load(5, 1'b0);
    push_load(3, 1'b0);
    push_load(2, 1'b0);
    push_load(-2, 1'b0);
    push_load(-9, 1'b1);

    // Pause the sender until all sorted output has come back
    wait_drained();

    // Store fills with no last marker, then random sets
    queue_set(SET_MAX, 1'b0);
    queue_batch(RANDOM_ITEMS / 2 - SET_MAX);
    wait_drained();

    // Full set marked last on its final value, then random sets
    queue_set(SET_MAX, 1'b1);
    queue_batch(RANDOM_ITEMS / 2 - SET_MAX);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Loaded %0d values in %0d sets (%0d ended by a full store).",
             loads_done, sets_closed, full_sets);
    $display("Checked %0d sorted transfers, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/msort_pkg.sv
hdl/msort_if.sv
hdl/msort_ram.sv
hdl/merge_sort_engine_unit.sv
hdl/msort_chk.sv
test/merge_sort_engine_unit_test.sv
